// ----- hw/rtl/bls_pkg.sv -----
// shared types, codes and constants for the bounded lifo stack
package bls_pkg;

	localparam int DEPTH  = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 9;
	localparam int CAP_W  = 9;
	localparam int WORD_W = 32;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;
	localparam logic [1:0] REQ_TOP  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_BADPOS    = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [WORD_W-1:0] push_value;
		logic [CNT_W-1:0]        peek_position;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [1:0]              status;
		logic [CNT_W-1:0]        entry_count;
		logic                    is_empty;
		logic                    is_full;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic respond;
	} cmd_t;

	// zero acts as one, anything above the store depth saturates
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CNT_W-1:0] res;
		if (cap == '0) begin
			res = CNT_W'(1);
		end else if (CNT_W'(cap) > CNT_W'(DEPTH)) begin
			res = CNT_W'(DEPTH);
		end else begin
			res = CNT_W'(cap);
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/bls_ram.sv -----
// generic single write port ram with registered read
module bls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/bls_ctrl.sv -----
// controller state machine: accept, execute, respond
module bls_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output bls_pkg::cmd_t   cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_RESP);

	always_comb begin
		cmd.load    = accept;
		cmd.exec    = (state_q == S_EXEC);
		cmd.respond = (state_q == S_RESP);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd.exec ##1 done)
		else $error("accepted transaction did not reach its result");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("controller still busy after result");

endmodule

// ----- hw/rtl/bls_dp.sv -----
// datapath: request registers, fill count, capacity, stack store and checks
module bls_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bls_pkg::cmd_t               cmd,
	input  bls_pkg::req_t               req,
	input  logic                        cfg_we,
	input  logic [bls_pkg::CAP_W-1:0]   cfg_wdata,
	output logic [bls_pkg::CAP_W-1:0]   cap,
	output bls_pkg::rsp_t               rsp
);

	logic [1:0]                        req_type_q;
	logic [bls_pkg::WORD_W-1:0]        push_value_q;
	logic [bls_pkg::CNT_W-1:0]         peek_position_q;
	logic [bls_pkg::CNT_W-1:0]         count_q;
	logic [bls_pkg::CAP_W-1:0]         cap_q;
	logic [1:0]                        status_q;
	logic                              rd_ok_q;

	logic [bls_pkg::CNT_W-1:0]         eff_cap;
	logic                              push_ok;
	logic                              nonempty;
	logic                              peek_ok;
	logic                              ram_we;
	logic                              ram_re;
	logic [bls_pkg::CNT_W-1:0]         rd_index;
	logic [bls_pkg::WORD_W-1:0]        ram_rdata;
	logic [1:0]                        status_d;
	logic [bls_pkg::CNT_W-1:0]         count_d;

	assign cap      = cap_q;
	assign eff_cap  = bls_pkg::eff_cap(cap_q);
	assign push_ok  = (count_q < eff_cap);
	assign nonempty = (count_q != '0);
	assign peek_ok  = (peek_position_q != '0) && (peek_position_q <= count_q);

	always_comb begin
		status_d = bls_pkg::ST_OK;
		count_d  = count_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		rd_index = count_q - bls_pkg::CNT_W'(1);
		unique case (req_type_q)
			bls_pkg::REQ_PUSH: begin
				if (push_ok) begin
					ram_we  = cmd.exec;
					count_d = count_q + bls_pkg::CNT_W'(1);
				end else begin
					status_d = bls_pkg::ST_OVERFLOW;
				end
			end
			bls_pkg::REQ_POP: begin
				if (nonempty) begin
					ram_re  = cmd.exec;
					count_d = count_q - bls_pkg::CNT_W'(1);
				end else begin
					status_d = bls_pkg::ST_UNDERFLOW;
				end
			end
			bls_pkg::REQ_PEEK: begin
				rd_index = count_q - peek_position_q;
				if (peek_ok) begin
					ram_re = cmd.exec;
				end else begin
					status_d = bls_pkg::ST_BADPOS;
				end
			end
			bls_pkg::REQ_TOP: begin
				if (nonempty) begin
					ram_re = cmd.exec;
				end else begin
					status_d = bls_pkg::ST_UNDERFLOW;
				end
			end
			default: status_d = bls_pkg::ST_OK;
		endcase
	end

	bls_ram #(
		.WIDTH(bls_pkg::WORD_W),
		.DEPTH(bls_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[bls_pkg::ADDR_W-1:0]),
		.wdata (push_value_q),
		.re    (ram_re),
		.raddr (rd_index[bls_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// request payload and execute results, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q      <= req.req_type;
			push_value_q    <= req.push_value;
			peek_position_q <= req.peek_position;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			rd_ok_q  <= ram_re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= bls_pkg::CAP_RESET;
		end else begin
			if (cmd.exec) begin
				count_q <= count_d;
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		rsp.read_value  = rd_ok_q ? ram_rdata : '1;
		rsp.status      = status_q;
		rsp.entry_count = count_q;
		rsp.is_empty    = (count_q == '0);
		rsp.is_full     = (count_q >= eff_cap);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bls_pkg::CNT_W'(bls_pkg::DEPTH))
		else $error("fill count beyond store depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("fill count moved outside execute cycle");

endmodule

// ----- hw/rtl/bounded_lifo_stack_core.sv -----
// bounded lifo stack of signed 32-bit words: top level
//
// requests come in on start/req; a transaction is taken at a clock edge with
// start high and busy low. req carries the request type (push, pop, peek at
// a position from the top, read top), the word to push and the peek position.
// each request gives exactly one result on rsp, shown for one cycle with done
// high: the word read (all ones on push or error), a status code, the entry
// count after the request and the empty and full flags.
// an item passes through accept, execute (store write or read address), then
// result once the store's registered read data is back; busy is high during
// execute and result, so no new request is taken until the result has gone.
// the receiver cannot stall; it must take rsp in the cycle done is high.
// the user writes the capacity register (byte address 0) via the apb-style
// port only while busy is low (not enforced); it resets to 256 entries.
// reset clears the entry count; store contents are left as they are and are
// only read below the count, so no clearing pass is needed.
module bounded_lifo_stack_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bls_pkg::req_t        req,
	output logic                 done,
	output bls_pkg::rsp_t        rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	bls_pkg::cmd_t               cmd;
	logic                        cfg_we;
	logic                        cap_sel;
	logic [bls_pkg::CAP_W-1:0]   cap;

	assign pready  = 1'b1;
	assign cap_sel = (paddr[2] == 1'b0);
	assign cfg_we  = psel && penable && pwrite && cap_sel;
	assign prdata  = cap_sel ? {{(32-bls_pkg::CAP_W){1'b0}}, cap} : 32'd0;

	bls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[bls_pkg::CAP_W-1:0]),
		.cap       (cap),
		.rsp       (rsp)
	);

endmodule

// ----- dv/bls_checker.sv -----
// scoreboard for the bounded lifo stack: predicts each result and compares it
`timescale 1ns / 100ps
module bls_checker #(
	parameter logic [2:0] CAP_ADDR = 3'd0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  bls_pkg::req_t             req,
	input  logic                      done,
	input  bls_pkg::rsp_t             rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	input  logic [31:0]               prdata,
	input  logic                      pready,
	output int                        fail_count,
	output int                        pending,
	output logic [bls_pkg::CNT_W-1:0] fill
);

	logic signed [bls_pkg::WORD_W-1:0] shadow_words [bls_pkg::DEPTH];
	logic [bls_pkg::CNT_W-1:0]         shadow_count;
	logic [bls_pkg::CAP_W-1:0]         shadow_cap;
	bls_pkg::rsp_t                     expected_rsp_q [$];

	// zero acts as one, values past the store depth clamp to it
	function automatic logic [bls_pkg::CNT_W-1:0] usable_depth(
		input logic [bls_pkg::CAP_W-1:0] cap);
		logic [bls_pkg::CNT_W-1:0] lim;
		lim = (cap == '0) ? bls_pkg::CNT_W'(1) : bls_pkg::CNT_W'(cap);
		if (int'(lim) > bls_pkg::DEPTH) begin
			lim = bls_pkg::CNT_W'(bls_pkg::DEPTH);
		end
		return lim;
	endfunction

	task automatic predict_stack_op(input bls_pkg::req_t r, output bls_pkg::rsp_t o);
		logic [bls_pkg::CNT_W-1:0] lim;
		lim = usable_depth(shadow_cap);
		o.read_value = -32'sd1;
		o.status     = bls_pkg::ST_OK;
		unique case (r.req_type)
			bls_pkg::REQ_PUSH: begin
				if (shadow_count >= lim) begin
					o.status = bls_pkg::ST_OVERFLOW;
				end else begin
					shadow_words[int'(shadow_count)] = r.push_value;
					shadow_count++;
				end
			end
			bls_pkg::REQ_POP: begin
				if (shadow_count == '0) begin
					o.status = bls_pkg::ST_UNDERFLOW;
				end else begin
					shadow_count--;
					o.read_value = shadow_words[int'(shadow_count)];
				end
			end
			bls_pkg::REQ_PEEK: begin
				if (r.peek_position == '0 || r.peek_position > shadow_count) begin
					o.status = bls_pkg::ST_BADPOS;
				end else begin
					o.read_value = shadow_words[int'(shadow_count - r.peek_position)];
				end
			end
			default: begin
				if (shadow_count == '0) begin
					o.status = bls_pkg::ST_UNDERFLOW;
				end else begin
					o.read_value = shadow_words[int'(shadow_count) - 1];
				end
			end
		endcase
		o.entry_count = shadow_count;
		o.is_empty    = (shadow_count == '0);
		o.is_full     = (shadow_count >= lim);
	endtask

	task automatic flag_failure(input string what);
		if (fail_count < 10) begin
			$display("%s", what);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bls_pkg::rsp_t want;
		bls_pkg::rsp_t predicted;
		if (!arst_n) begin
			shadow_count = '0;
			shadow_cap   = bls_pkg::CAP_RESET;
			fail_count   = 0;
			expected_rsp_q.delete();
		end else begin
			// a result leaving and a request entering on one edge: the result is older
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					flag_failure($sformatf("unexpected result at %0t: value %0d status %0d",
						$time, rsp.read_value, rsp.status));
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
					    rsp.entry_count !== want.entry_count ||
					    rsp.is_empty !== want.is_empty || rsp.is_full !== want.is_full) begin
						flag_failure($sformatf({"result mismatch at %0t: exp value %0d status %0d",
							" count %0d empty %0b full %0b, got value %0d status %0d",
							" count %0d empty %0b full %0b"}, $time,
							want.read_value, want.status, want.entry_count, want.is_empty,
							want.is_full, rsp.read_value, rsp.status, rsp.entry_count,
							rsp.is_empty, rsp.is_full));
					end
				end
			end
			if (start && !busy) begin
				predict_stack_op(req, predicted);
				expected_rsp_q.push_back(predicted);
			end
			if (psel && penable && pready && paddr == CAP_ADDR) begin
				if (pwrite) begin
					shadow_cap = pwdata[bls_pkg::CAP_W-1:0];
				end else if (prdata !== 32'(shadow_cap)) begin
					flag_failure($sformatf("capacity read mismatch at %0t: exp %0d got %0d",
						$time, shadow_cap, prdata));
				end
			end
		end
		pending = expected_rsp_q.size();
		fill    = shadow_count;
	end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for the bounded lifo stack: stimulus, clock, reset and verdict
`timescale 1ns / 100ps
module tb_top;

	localparam logic [2:0] CAP_ADDR    = 3'd0;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         ITEM_GOAL   = 1100;

	// stack op mix for a phase
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	bls_pkg::req_t             req;
	logic                      done;
	bls_pkg::rsp_t             rsp;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [2:0]                paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	int                        fail_count;
	int                        pending;
	logic [bls_pkg::CNT_W-1:0] fill;
	int                        cycles = 0;
	int                        items_sent;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	bounded_lifo_stack_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bls_checker #(.CAP_ADDR(CAP_ADDR)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.fill       (fill)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// wait out every outstanding transaction plus the pipeline tail
	task automatic wait_drained();
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel    = 1'b1;
		pwrite  = wr;
		paddr   = CAP_ADDR;
		pwdata  = data;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_capacity(input int cap);
		wait_drained();
		apb_access(1'b1, 32'(cap));
		apb_access(1'b0, 32'd0);
	endtask

	task automatic send_request(input logic [1:0] op, input logic [31:0] value, input int pos);
		start             = 1'b1;
		req.req_type      = op;
		req.push_value    = value;
		req.peek_position = bls_pkg::CNT_W'(pos);
		while (busy) begin
			@(negedge clk);
		end
		@(negedge clk);
		start = 1'b0;
		items_sent++;
	endtask

	task automatic sender_gap(input bit quiet);
		int k;
		int n;
		k = $urandom_range(0, 99);
		n = 0;
		if (!quiet) begin
			if (k < 60) begin
				n = 0;
			end else if (k < 90) begin
				n = $urandom_range(1, 3);
			end else begin
				n = $urandom_range(5, 40);
			end
		end
		repeat (n) @(negedge clk);
	endtask

	task automatic random_request(input op_mix_t mix);
		int          r;
		int          k;
		int          f;
		int          pos;
		logic [1:0]  op;
		logic [31:0] value;
		r = $urandom_range(0, 99);
		f = int'(fill);
		unique case (mix)
			MIX_FILL: begin
				op = (r < 88) ? bls_pkg::REQ_PUSH : (r < 93) ? bls_pkg::REQ_POP :
					(r < 97) ? bls_pkg::REQ_PEEK : bls_pkg::REQ_TOP;
			end
			MIX_DRAIN: begin
				op = (r < 10) ? bls_pkg::REQ_PUSH : (r < 80) ? bls_pkg::REQ_POP :
					(r < 92) ? bls_pkg::REQ_PEEK : bls_pkg::REQ_TOP;
			end
			default: begin
				op = (r < 35) ? bls_pkg::REQ_PUSH : (r < 65) ? bls_pkg::REQ_POP :
					(r < 88) ? bls_pkg::REQ_PEEK : bls_pkg::REQ_TOP;
			end
		endcase
		k = $urandom_range(0, 15);
		unique case (k)
			0:       value = 32'h7fff_ffff;
			1:       value = 32'h8000_0000;
			2:       value = 32'hffff_ffff;
			3:       value = 32'h0000_0000;
			default: value = $urandom;
		endcase
		k = $urandom_range(0, 9);
		if (k == 0) begin
			pos = 0;
		end else if (k == 1) begin
			pos = (f >= bls_pkg::DEPTH) ? bls_pkg::DEPTH : f + 1;
		end else if (k == 2) begin
			pos = $urandom_range(0, bls_pkg::DEPTH);
		end else begin
			pos = (f == 0) ? 1 : $urandom_range(1, f);
		end
		send_request(op, value, pos);
	endtask

	initial begin : stimulus
		int      phase;
		int      cap;
		int      len;
		int      k;
		bit      quiet;
		op_mix_t mix;

		arst_n  = 1'b0;
		start   = 1'b0;
		req     = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = CAP_ADDR;
		pwdata  = '0;
		items_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset value of the capacity register
		apb_access(1'b0, 32'd0);

		// empty stack errors, word extremes, peek bounds
		send_request(bls_pkg::REQ_POP, 32'd0, 0);
		send_request(bls_pkg::REQ_TOP, 32'd0, 0);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 0);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 1);
		send_request(bls_pkg::REQ_PUSH, 32'h7fff_ffff, 0);
		send_request(bls_pkg::REQ_PUSH, 32'h8000_0000, 0);
		send_request(bls_pkg::REQ_PUSH, 32'hffff_ffff, 0);
		send_request(bls_pkg::REQ_PUSH, 32'h0000_0000, 0);
		send_request(bls_pkg::REQ_TOP, 32'd0, 0);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 1);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 4);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 5);
		send_request(bls_pkg::REQ_PEEK, 32'd0, bls_pkg::DEPTH);
		repeat (5) send_request(bls_pkg::REQ_POP, 32'd0, 0);

		// tiny capacity: overflow and full flag
		set_capacity(2);
		repeat (3) send_request(bls_pkg::REQ_PUSH, $urandom, 0);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 2);
		send_request(bls_pkg::REQ_PEEK, 32'd0, 3);
		repeat (2) send_request(bls_pkg::REQ_POP, 32'd0, 0);

		// zero capacity behaves as one
		set_capacity(0);
		repeat (2) send_request(bls_pkg::REQ_PUSH, $urandom, 0);
		send_request(bls_pkg::REQ_TOP, 32'd0, 0);
		send_request(bls_pkg::REQ_POP, 32'd0, 0);

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			unique case (phase)
				0: begin cap = 511; mix = MIX_FILL;     len = 340; end
				1: begin cap = 256; mix = MIX_BALANCED; len = 60;  end
				// capacity now far below the count
				2: begin cap = 3;   mix = MIX_DRAIN;    len = 300; end
				3: begin cap = 1;   mix = MIX_BALANCED; len = 30;  end
				4: begin cap = 257; mix = MIX_BALANCED; len = 40;  end
				5: begin cap = 255; mix = MIX_FILL;     len = 40;  end
				default: begin
					k = $urandom_range(0, 9);
					if (k < 3) begin
						unique case ($urandom_range(0, 3))
							0:       cap = 0;
							1:       cap = 1;
							2:       cap = 256;
							default: cap = 511;
						endcase
					end else if (k < 7) begin
						cap = $urandom_range(1, 16);
					end else begin
						cap = $urandom_range(1, 511);
					end
					mix = op_mix_t'($urandom_range(0, 2));
					len = $urandom_range(20, 80);
				end
			endcase
			set_capacity(cap);
			quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
			repeat (len) begin
				random_request(mix);
				if ($urandom_range(0, 199) == 0) begin
					wait_drained();
				end
				sender_gap(quiet);
			end
			phase++;
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
